// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions that are disabled while reset is applied.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	`ASSERT_PROP(label, clk, rst_n, !(expr), msg)

`endif

// ===== hdl/pbc_pkg.sv =====
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types, codes and sizes of the pixel blit compositor.
// ----------------------------------------------------------------------------
package pbc_pkg;

	// Frame store size in pixels.
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int FRAME_WORDS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW          = $clog2(FRAME_WORDS);
	localparam int XW          = $clog2(MAX_WIDTH);
	localparam int YW          = $clog2(MAX_HEIGHT);

	// Width that holds a clamped destination size, and the width used to
	// compare it against an 11-bit coordinate.
	localparam int DIMW_A = $clog2(MAX_WIDTH + 1);
	localparam int DIMW_B = $clog2(MAX_HEIGHT + 1);
	localparam int DIMW_C = (DIMW_A > DIMW_B) ? DIMW_A : DIMW_B;
	localparam int DIMW   = (DIMW_C > 9) ? DIMW_C : 9;
	localparam int CW     = (DIMW > 11) ? DIMW : 11;

	// Result buffer; the depth must be a power of two.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
	localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [7:0] FULL_ALPHA = 8'hFF;

	typedef enum logic [1:0] {
		CMD_BLIT = 2'd0,
		CMD_SET  = 2'd1,
		CMD_GET  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_COPY  = 2'd0,
		MODE_KEY   = 2'd1,
		MODE_BLEND = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		OUT_WRITTEN = 2'd0,
		OUT_OUTSIDE = 2'd1,
		OUT_SKIPPED = 2'd2,
		OUT_READ    = 2'd3
	} outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEST_WIDTH  = 3'd0,
		REG_DEST_HEIGHT = 3'd1,
		REG_BLIT_MODE   = 3'd2,
		REG_KEY_COLOR   = 3'd3,
		REG_OFFSET_X    = 3'd4,
		REG_OFFSET_Y    = 3'd5
	} cfg_reg_t;

	// Word layout of the frame store: red in the low byte, alpha on top.
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		outcome_t outcome;
		pixel_t   pixel;
	} result_t;

endpackage

// ===== hdl/pbc_frame_ram.sv =====
// ----------------------------------------------------------------------------
// pbc_frame_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pbc_frame_ram #(
	parameter  int DEPTH = 65536,
	parameter  int DW    = 32,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/pbc_blend.sv =====
// ----------------------------------------------------------------------------
// pbc_blend
// Two-stage alpha blend: per-channel products, then sum and divide by 255.
// ----------------------------------------------------------------------------
module pbc_blend import pbc_pkg::*; (
	input  logic   clk,
	input  pixel_t src_s2,
	input  pixel_t dst_s2,
	output pixel_t blend_s3
);

	logic [2:0][7:0]  src_rgb;
	logic [2:0][7:0]  dst_rgb;
	logic [7:0]       inv_alpha;
	logic [15:0]      src_prod_s3 [3];
	logic [15:0]      dst_prod_s3 [3];
	logic [2:0][7:0]  mix_rgb;

	assign src_rgb   = {src_s2.blue, src_s2.green, src_s2.red};
	assign dst_rgb   = {dst_s2.blue, dst_s2.green, dst_s2.red};
	assign inv_alpha = FULL_ALPHA - src_s2.alpha;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			src_prod_s3[i] <= 16'(src_rgb[i]) * 16'(src_s2.alpha);
			dst_prod_s3[i] <= 16'(dst_rgb[i]) * 16'(inv_alpha);
		end
	end

	// The sum never exceeds 255*255, where (v + (v >> 8) + 1) >> 8 equals v / 255.
	always_comb begin
		logic [15:0] sum;
		logic [16:0] quo;
		for (int i = 0; i < 3; i++) begin
			sum        = src_prod_s3[i] + dst_prod_s3[i];
			quo        = 17'(sum) + 17'(sum[15:8]) + 17'd1;
			mix_rgb[i] = quo[15:8];
		end
	end

	assign blend_s3 = '{alpha: FULL_ALPHA, blue: mix_rgb[2], green: mix_rgb[1],
		red: mix_rgb[0]};

endmodule

// ===== hdl/pbc_out_fifo.sv =====
// ----------------------------------------------------------------------------
// pbc_out_fifo
// Result buffer between the pixel pipeline and the output channel.
// ----------------------------------------------------------------------------
module pbc_out_fifo import pbc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    stall,
	output logic    valid,
	output result_t head
);

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0]   wr_ptr_q;
	logic [FIFO_PW-1:0]   rd_ptr_q;
	logic [PEND_W-1:0]    count_q;
	logic                 pop;

	assign valid = (count_q != '0);
	assign pop   = valid && !stall;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/pixel_blit_compositor.sv =====
// ----------------------------------------------------------------------------
// pixel_blit_compositor
// 2D blitter over an RGBA8888 frame store with copy, color key and alpha
// blend, plus direct pixel set and get.
//
// Channel  Handshake              Payload
// in       in_valid / in_stall    cmd, coord_x, coord_y, red, green, blue, alpha
// out      out_valid / out_stall  out_red, out_green, out_blue, out_alpha, outcome
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while in_stall is low; each result goes through the pipeline
// registers into the result buffer. An item that reads a pixel directly behind
// one that writes the same pixel waits in stage 1, since the frame RAM's single
// read port sees the write late. After reset a clearing pass writes zero to all
// MAX_WIDTH*MAX_HEIGHT words; no item is taken until it ends, configuration
// writes are. Up to eight results are buffered while out_stall is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pixel_blit_compositor import pbc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            cmd,
	input  logic signed [10:0]    coord_x,
	input  logic signed [10:0]    coord_y,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	input  logic [7:0]            alpha,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_red,
	output logic [7:0]            out_green,
	output logic [7:0]            out_blue,
	output logic [7:0]            out_alpha,
	output logic [1:0]            outcome
);

	// Configuration
	logic [8:0]         dest_width_q;
	logic [8:0]         dest_height_q;
	mode_t              blit_mode_q;
	logic [23:0]        key_color_q;
	logic signed [10:0] offset_x_q;
	logic signed [10:0] offset_y_q;

	// Clearing pass
	logic               clr_active_q;
	logic [AW-1:0]      clr_addr_q;

	// Stage 1: destination coordinates
	logic               v_s1;
	cmd_t               cmd_s1;
	logic signed [11:0] x_s1;
	logic signed [11:0] y_s1;
	pixel_t             pix_s1;

	// Stage 2: frame word read back
	logic               v_s2;
	logic               wr_s2;
	logic               rd_s2;
	logic               blend_s2;
	outcome_t           outcome_s2;
	logic [AW-1:0]      addr_s2;
	logic [XW-1:0]      x_s2;
	logic [YW-1:0]      y_s2;
	pixel_t             pix_s2;

	// Stage 3: write back and result
	logic               v_s3;
	logic               wr_s3;
	logic               blend_s3;
	outcome_t           outcome_s3;
	logic [AW-1:0]      addr_s3;
	pixel_t             pix_s3;
	pixel_t             dst_s3;

	// Last write to the RAM, for the item whose read saw the old word.
	logic               fwd_v_q;
	logic [AW-1:0]      fwd_addr_q;
	pixel_t             fwd_data_q;

	logic [PEND_W-1:0]  pend_q;

	logic [DIMW-1:0]    eff_w;
	logic [DIMW-1:0]    eff_h;
	logic               dest_hit;
	logic [AW-1:0]      addr_c;
	logic               wr_c;
	logic               rd_c;
	logic               blend_c;
	outcome_t           outcome_c;
	logic               hazard;
	logic               accept;
	logic               deliver;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	pixel_t             ram_wdata;
	logic [31:0]        ram_rdata;
	pixel_t             dst_s2;
	pixel_t             mix_s3;
	pixel_t             word_s3;
	result_t            res_s3;
	result_t            head;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_width_q  <= 9'd256;
			dest_height_q <= 9'd256;
			blit_mode_q   <= MODE_COPY;
			key_color_q   <= '0;
			offset_x_q    <= '0;
			offset_y_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEST_WIDTH:  dest_width_q  <= cfg_data[8:0];
				REG_DEST_HEIGHT: dest_height_q <= cfg_data[8:0];
				REG_BLIT_MODE:   blit_mode_q   <= mode_t'(cfg_data[1:0]);
				REG_KEY_COLOR:   key_color_q   <= cfg_data[23:0];
				REG_OFFSET_X:    offset_x_q    <= cfg_data[10:0];
				REG_OFFSET_Y:    offset_y_q    <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input acceptance and stage 1
	// ------------------------------------------------------------------
	assign deliver  = out_valid && !out_stall;
	assign in_stall = clr_active_q || hazard || (pend_q == PEND_W'(FIFO_DEPTH));
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (!hazard) begin
			v_s1 <= 1'b0;
		end
	end

	// Only a blit is moved by the destination offset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_t'(cmd);
			x_s1   <= {coord_x[10], coord_x} + ((cmd == CMD_BLIT) ?
				{offset_x_q[10], offset_x_q} : 12'sd0);
			y_s1   <= {coord_y[10], coord_y} + ((cmd == CMD_BLIT) ?
				{offset_y_q[10], offset_y_q} : 12'sd0);
			pix_s1 <= '{alpha: alpha, blue: blue, green: green, red: red};
		end
	end

	// Clip against the destination and form the frame address.
	assign eff_w = (DIMW'(dest_width_q) > DIMW'(MAX_WIDTH)) ?
		DIMW'(MAX_WIDTH) : DIMW'(dest_width_q);
	assign eff_h = (DIMW'(dest_height_q) > DIMW'(MAX_HEIGHT)) ?
		DIMW'(MAX_HEIGHT) : DIMW'(dest_height_q);

	assign dest_hit = !x_s1[11] && !y_s1[11]
		&& (CW'(x_s1[10:0]) < CW'(eff_w))
		&& (CW'(y_s1[10:0]) < CW'(eff_h));

	assign addr_c = AW'(AW'(y_s1[YW-1:0]) * AW'(eff_w) + AW'(x_s1[XW-1:0]));

	always_comb begin
		wr_c      = 1'b0;
		rd_c      = 1'b0;
		blend_c   = 1'b0;
		outcome_c = OUT_SKIPPED;
		case (cmd_s1)
			CMD_BLIT: begin
				case (blit_mode_q)
					MODE_KEY: begin
						wr_c = ({pix_s1.blue, pix_s1.green, pix_s1.red} != key_color_q);
					end
					MODE_BLEND: begin
						blend_c = 1'b1;
						wr_c    = (pix_s1.alpha != 8'd0);
						// Full alpha ignores the old word, so it needs no read.
						rd_c    = (pix_s1.alpha != 8'd0) && (pix_s1.alpha != FULL_ALPHA);
					end
					default: wr_c = 1'b1;
				endcase
			end
			CMD_SET: wr_c = 1'b1;
			default: rd_c = 1'b1;
		endcase
		if (!dest_hit) begin
			wr_c      = 1'b0;
			rd_c      = 1'b0;
			outcome_c = OUT_OUTSIDE;
		end else if (cmd_s1 != CMD_BLIT && cmd_s1 != CMD_SET) begin
			outcome_c = OUT_READ;
		end else if (wr_c) begin
			outcome_c = OUT_WRITTEN;
		end
	end

	// Both items are inside, so equal coordinates mean the same word.
	assign hazard = v_s1 && rd_c && v_s2 && wr_s2
		&& (x_s1[XW-1:0] == x_s2) && (y_s1[YW-1:0] == y_s2);

	// ------------------------------------------------------------------
	// Stage 2
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && !hazard;
		end
	end

	always_ff @(posedge clk) begin
		if (!hazard) begin
			wr_s2      <= wr_c;
			rd_s2      <= rd_c;
			blend_s2   <= blend_c;
			outcome_s2 <= outcome_c;
			addr_s2    <= addr_c;
			x_s2       <= x_s1[XW-1:0];
			y_s2       <= y_s1[YW-1:0];
			pix_s2     <= pix_s1;
		end
	end

	assign dst_s2 = (fwd_v_q && (fwd_addr_q == addr_s2)) ? fwd_data_q : pixel_t'(ram_rdata);

	pbc_blend u_blend (
		.clk      (clk),
		.src_s2   (pix_s2),
		.dst_s2   (dst_s2),
		.blend_s3 (mix_s3)
	);

	// ------------------------------------------------------------------
	// Stage 3
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		wr_s3      <= wr_s2;
		blend_s3   <= blend_s2;
		outcome_s3 <= outcome_s2;
		addr_s3    <= addr_s2;
		pix_s3     <= pix_s2;
		dst_s3     <= dst_s2;
	end

	assign word_s3 = blend_s3 ? mix_s3 : pix_s3;

	assign res_s3.outcome = outcome_s3;
	assign res_s3.pixel   = (outcome_s3 == OUT_READ) ? dst_s3 : '0;

	// ------------------------------------------------------------------
	// Frame store and clearing pass
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == AW'(FRAME_WORDS - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign ram_we    = clr_active_q || (v_s3 && wr_s3);
	assign ram_waddr = clr_active_q ? clr_addr_q : addr_s3;
	assign ram_wdata = clr_active_q ? '0 : word_s3;

	pbc_frame_ram #(
		.DEPTH (FRAME_WORDS),
		.DW    (32)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_c),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else begin
			fwd_v_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= ram_waddr;
		fwd_data_q <= ram_wdata;
	end

	// ------------------------------------------------------------------
	// Results
	// ------------------------------------------------------------------
	// Counts items taken whose results have not left, so the buffer never overflows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({accept, deliver})
				2'b10: pend_q <= pend_q + 1'b1;
				2'b01: pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	pbc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_data (res_s3),
		.stall     (out_stall),
		.valid     (out_valid),
		.head      (head)
	);

	assign out_red   = head.pixel.red;
	assign out_green = head.pixel.green;
	assign out_blue  = head.pixel.blue;
	assign out_alpha = head.pixel.alpha;
	assign outcome   = head.outcome;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ASSERT_NEVER(a_pend_bound, clk, arst_n, pend_q > PEND_W'(FIFO_DEPTH),
		"more transactions in flight than the result buffer holds")
	`ASSERT_NEVER(a_no_stale_read, clk, arst_n,
		v_s2 && rd_s2 && v_s3 && wr_s3 && (addr_s2 == addr_s3),
		"read of a pixel that the item ahead is still writing")
	`ASSERT_NEVER(a_clear_quiet, clk, arst_n, clr_active_q && (v_s1 || v_s2 || v_s3),
		"pixel transaction in flight during the clearing pass")
	`ASSERT_PROP(a_result_queued, clk, arst_n, v_s3 |=> out_valid,
		"finished transaction did not reach the output")

endmodule
